/* sv/qphs_pkg.sv */
// Shared constants, command codes and transfer types for the quadratic probe hash set.
`default_nettype none

package qphs_pkg;

  localparam int unsigned TABLE_SLOTS = 16;
  localparam int unsigned SLOT_W      = $clog2(TABLE_SLOTS);
  localparam int unsigned KEY_W       = 32;
  localparam int unsigned CMD_W       = 2;

  localparam int unsigned DIGIT_W = 2;
  localparam int unsigned DIGITS  = KEY_W / DIGIT_W;
  localparam int unsigned DCNT_W  = $clog2(DIGITS);
  localparam int unsigned MOD_W   = SLOT_W + DIGIT_W;

  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QPTR_W = 1;
  localparam int unsigned QCNT_W = 2;

  typedef logic [CMD_W-1:0]  cmd_t;
  typedef logic [SLOT_W-1:0] slot_t;
  typedef logic [KEY_W-1:0]  key_t;

  localparam cmd_t CMD_INSERT = 2'd0;
  localparam cmd_t CMD_FIND   = 2'd1;
  localparam cmd_t CMD_DELETE = 2'd2;

  typedef struct packed {
    cmd_t  command;
    logic  probe;
    key_t  key;
    slot_t home;
  } req_t;

  typedef struct packed {
    logic valid;
    req_t req;
  } req_xfer_t;

endpackage

`default_nettype wire

/* sv/quadratic_probe_hash_set.sv */
// Top level of the quadratic probe hash set: front end, request queue and probe engine.
`default_nettype none

// Open-addressed hash set of 32-bit keys with quadratic probing and tombstones. Each
// request (insert, find or delete) returns one success bit, in request order. After
// reset the slot flags are swept one slot at a time, during which no request is
// taken. The front end reduces each key to its home slot two bits per cycle, so it
// takes a new request only after the last one has passed accept, 16 reduction steps
// and queue hand-off. The probe engine reads one slot per cycle from its slot store
// and walks at most TABLE_SLOTS probes per request; an unused command code skips the
// walk. The engine takes its next request only once the last result has been taken.
// A two-entry queue between the two lets the front end accept and reduce new requests
// while the engine probes or its result waits to be taken.
module quadratic_probe_hash_set
  import qphs_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  cmd_t in_command,
  input  key_t in_search_key,
  output logic out_valid,
  input  logic out_stall,
  output logic out_success
);

  req_xfer_t push;
  req_xfer_t pop;
  logic      push_full;
  logic      pop_take;
  logic      clearing;

  qphs_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .hold          (clearing),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_command    (in_command),
    .in_search_key (in_search_key),
    .push          (push),
    .push_full     (push_full)
  );

  qphs_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_full (push_full),
    .pop       (pop),
    .pop_take  (pop_take)
  );

  qphs_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .pop         (pop),
    .pop_take    (pop_take),
    .clearing    (clearing),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_success (out_success)
  );

endmodule

`default_nettype wire

/* sv/qphs_front.sv */
// Front end: accept a request, classify its command and reduce the key to its home slot.
`default_nettype none

module qphs_front
  import qphs_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      hold,
  input  logic      in_valid,
  output logic      in_stall,
  input  cmd_t      in_command,
  input  key_t      in_search_key,
  output req_xfer_t push,
  input  logic      push_full
);

  typedef enum logic [1:0] {
    F_IDLE,
    F_MOD,
    F_PUSH
  } state_t;

  localparam logic [MOD_W-1:0] MOD_N1 = MOD_W'(TABLE_SLOTS);
  localparam logic [MOD_W-1:0] MOD_N2 = MOD_W'(2 * TABLE_SLOTS);
  localparam logic [MOD_W-1:0] MOD_N3 = MOD_W'(3 * TABLE_SLOTS);

  state_t            state_r;
  cmd_t              cmd_r;
  key_t              key_r;
  key_t              sh_r;
  slot_t             rem_r;
  logic [DCNT_W-1:0] dcnt_r;

  logic [MOD_W-1:0]  part;
  logic [MOD_W-1:0]  part_red;
  slot_t             rem_nxt;

  assign in_stall = (state_r != F_IDLE) || hold;

  always_comb begin
    part = {rem_r, sh_r[KEY_W-1 -: DIGIT_W]};
    priority if (part >= MOD_N3) begin
      part_red = part - MOD_N3;
    end else if (part >= MOD_N2) begin
      part_red = part - MOD_N2;
    end else if (part >= MOD_N1) begin
      part_red = part - MOD_N1;
    end else begin
      part_red = part;
    end
    rem_nxt = part_red[SLOT_W-1:0];
  end

  always_comb begin
    push.valid         = (state_r == F_PUSH);
    push.req.command   = cmd_r;
    push.req.probe     = (cmd_r == CMD_INSERT) || (cmd_r == CMD_FIND) ||
                         (cmd_r == CMD_DELETE);
    push.req.key       = key_r;
    push.req.home      = rem_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
      dcnt_r  <= '0;
    end else begin
      unique case (state_r)
        F_IDLE: begin
          if (in_valid && !in_stall) begin
            cmd_r   <= in_command;
            key_r   <= in_search_key;
            sh_r    <= in_search_key;
            rem_r   <= '0;
            dcnt_r  <= '0;
            state_r <= F_MOD;
          end
        end
        F_MOD: begin
          rem_r  <= rem_nxt;
          sh_r   <= sh_r << DIGIT_W;
          dcnt_r <= dcnt_r + DCNT_W'(1);
          if (dcnt_r == DCNT_W'(DIGITS - 1)) begin
            state_r <= F_PUSH;
          end
        end
        F_PUSH: begin
          if (!push_full) begin
            state_r <= F_IDLE;
          end
        end
        default: begin
          state_r <= F_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

/* sv/qphs_queue.sv */
// Short request queue between the front end and the probe engine.
`default_nettype none

module qphs_queue
  import qphs_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  req_xfer_t push,
  output logic      push_full,
  output req_xfer_t pop,
  input  logic      pop_take
);

  req_t              ent_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QCNT_W-1:0] cnt_r;
  logic              do_push;
  logic              do_pop;

  assign push_full = (cnt_r == QCNT_W'(QDEPTH));
  assign do_push   = push.valid && !push_full;
  assign do_pop    = pop_take && pop.valid;

  always_comb begin
    pop.valid = (cnt_r != '0);
    pop.req   = ent_r[rd_ptr_r];
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      ent_r[wr_ptr_r] <= push.req;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      end
      unique case ({do_push, do_pop})
        2'b10:   cnt_r <= cnt_r + QCNT_W'(1);
        2'b01:   cnt_r <= cnt_r - QCNT_W'(1);
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

`default_nettype wire

/* sv/qphs_back.sv */
// Probe engine: slot store, clearing pass, quadratic probe walk and result register.
`default_nettype none

module qphs_back
  import qphs_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  req_xfer_t pop,
  output logic      pop_take,
  output logic      clearing,
  output logic      out_valid,
  input  logic      out_stall,
  output logic      out_success
);

  typedef enum logic [1:0] {
    B_CLEAR,
    B_IDLE,
    B_PROBE
  } state_t;

  typedef struct packed {
    logic used;
    logic tomb;
  } flag_t;

  localparam slot_t ONE_MOD   = SLOT_W'(1 % TABLE_SLOTS);
  localparam slot_t TWO_MOD   = SLOT_W'(2 % TABLE_SLOTS);
  localparam slot_t THREE_MOD = SLOT_W'(3 % TABLE_SLOTS);
  localparam slot_t LAST_SLOT = SLOT_W'(TABLE_SLOTS - 1);

  function automatic slot_t add_mod(slot_t a, slot_t b);
    logic [SLOT_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= (SLOT_W + 1)'(TABLE_SLOTS)) begin
      s = s - (SLOT_W + 1)'(TABLE_SLOTS);
    end
    return s[SLOT_W-1:0];
  endfunction

  key_t  key_mem  [TABLE_SLOTS];
  flag_t flag_mem [TABLE_SLOTS];

  state_t state_r;
  slot_t  clr_addr_r;
  req_t   req_r;
  slot_t  cur_r;
  slot_t  nxt_r;
  slot_t  step_r;
  slot_t  idx_r;
  logic   out_valid_r;
  logic   out_success_r;
  key_t   key_rd_r;
  flag_t  flag_rd_r;

  slot_t  rd_addr;
  logic   key_we;
  logic   flag_we;
  slot_t  flag_waddr;
  flag_t  flag_wdata;

  logic   last;
  logic   is_insert;
  logic   free_slot;
  logic   empty_slot;
  logic   match;
  logic   done;
  logic   hit;

  assign clearing    = (state_r == B_CLEAR);
  assign out_valid   = out_valid_r;
  assign out_success = out_success_r;
  assign pop_take    = (state_r == B_IDLE) && pop.valid && !out_valid_r;

  always_comb begin
    last       = (idx_r == LAST_SLOT);
    is_insert  = (req_r.command == CMD_INSERT);
    free_slot  = !flag_rd_r.used || flag_rd_r.tomb;
    empty_slot = !flag_rd_r.used;
    match      = flag_rd_r.used && !flag_rd_r.tomb && (key_rd_r == req_r.key);
    hit        = is_insert ? free_slot : match;
    done       = hit || last || (!is_insert && empty_slot);
  end

  always_comb begin
    rd_addr         = cur_r;
    key_we          = 1'b0;
    flag_we         = 1'b0;
    flag_waddr      = cur_r;
    flag_wdata.used = 1'b0;
    flag_wdata.tomb = 1'b0;
    unique case (state_r)
      B_CLEAR: begin
        flag_we    = 1'b1;
        flag_waddr = clr_addr_r;
      end
      B_IDLE: begin
        rd_addr = pop.req.home;
      end
      B_PROBE: begin
        if (done) begin
          if (hit) begin
            key_we          = is_insert;
            flag_we         = is_insert || (req_r.command == CMD_DELETE);
            flag_wdata.used = 1'b1;
            flag_wdata.tomb = !is_insert;
          end
        end else begin
          rd_addr = nxt_r;
        end
      end
      default: begin
        rd_addr = cur_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (key_we) begin
      key_mem[cur_r] <= req_r.key;
    end
    if (flag_we) begin
      flag_mem[flag_waddr] <= flag_wdata;
    end
    key_rd_r  <= key_mem[rd_addr];
    flag_rd_r <= flag_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_CLEAR;
      clr_addr_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        B_CLEAR: begin
          clr_addr_r <= clr_addr_r + SLOT_W'(1);
          if (clr_addr_r == LAST_SLOT) begin
            state_r <= B_IDLE;
          end
        end
        B_IDLE: begin
          if (pop_take) begin
            req_r <= pop.req;
            if (pop.req.probe) begin
              cur_r   <= pop.req.home;
              nxt_r   <= add_mod(pop.req.home, ONE_MOD);
              step_r  <= THREE_MOD;
              idx_r   <= '0;
              state_r <= B_PROBE;
            end else begin
              out_valid_r   <= 1'b1;
              out_success_r <= 1'b0;
            end
          end
        end
        B_PROBE: begin
          if (done) begin
            out_valid_r   <= 1'b1;
            out_success_r <= hit;
            state_r       <= B_IDLE;
          end else begin
            cur_r  <= nxt_r;
            nxt_r  <= add_mod(nxt_r, step_r);
            step_r <= add_mod(step_r, TWO_MOD);
            idx_r  <= idx_r + SLOT_W'(1);
          end
        end
        default: begin
          state_r <= B_IDLE;
        end
      endcase
    end
  end

  a_key_write_sets_live: assert property (@(posedge clk) disable iff (!rst_n)
    key_we |-> (flag_we && flag_wdata.used && !flag_wdata.tomb))
    else $error("key written without marking the slot live");

  a_take_needs_free_result: assert property (@(posedge clk) disable iff (!rst_n)
    pop_take |-> !out_valid_r)
    else $error("request taken while a result is pending");

  a_result_has_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r == B_PROBE) || $past(pop_take)))
    else $error("result raised without a request behind it");

  a_clear_is_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    clearing |-> (!pop_take && !out_valid_r))
    else $error("activity during the clearing pass");

endmodule

`default_nettype wire

/* dv/tb_quadratic_probe_hash_set.sv */
// Testbench for the quadratic probe hash set: directed and random requests checked against a predictor.
module tb_quadratic_probe_hash_set;
  import qphs_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam cmd_t CMD_UNUSED = 2'd3;
  localparam int unsigned RANDOM_PER_PHASE = 408;
  localparam int unsigned POOL_SIZE = 20;
  localparam int unsigned MAX_REPORTS = 10;
  localparam int unsigned DRAIN_CYCLES = 40;

  typedef struct packed {
    cmd_t command;
    key_t key;
    logic fixed;
    logic answer;
  } directed_req_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  cmd_t in_command = CMD_INSERT;
  key_t in_search_key = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic out_success;

  key_t stored_key [TABLE_SLOTS];
  bit stored_full [TABLE_SLOTS];
  bit stored_dead [TABLE_SLOTS];

  bit expected_success [$];
  int unsigned fail_count = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  key_t key_pool [POOL_SIZE];

  directed_req_t directed_reqs [25] = '{
    '{CMD_FIND, 32'h0000_0000, 1'b1, 1'b0},
    '{CMD_DELETE, 32'hFFFF_FFFF, 1'b1, 1'b0},
    '{CMD_UNUSED, 32'h0000_0000, 1'b1, 1'b0},
    '{CMD_INSERT, 32'h0000_0000, 1'b1, 1'b1},
    '{CMD_INSERT, 32'hFFFF_FFFF, 1'b1, 1'b1},
    '{CMD_FIND, 32'h0000_0000, 1'b0, 1'b0},
    '{CMD_FIND, 32'hFFFF_FFFF, 1'b0, 1'b0},
    '{CMD_INSERT, 32'h0000_0010, 1'b0, 1'b0},
    '{CMD_INSERT, 32'h0000_0010, 1'b0, 1'b0},
    '{CMD_FIND, 32'h0000_0010, 1'b0, 1'b0},
    '{CMD_DELETE, 32'h0000_0010, 1'b0, 1'b0},
    '{CMD_FIND, 32'h0000_0010, 1'b0, 1'b0},
    '{CMD_DELETE, 32'h0000_0010, 1'b0, 1'b0},
    '{CMD_FIND, 32'h0000_0010, 1'b0, 1'b0},
    '{CMD_INSERT, 32'h0000_0020, 1'b0, 1'b0},
    '{CMD_UNUSED, 32'hFFFF_FFFF, 1'b1, 1'b0},
    '{CMD_DELETE, 32'h0000_0000, 1'b0, 1'b0},
    '{CMD_FIND, 32'h0000_0000, 1'b0, 1'b0},
    '{CMD_INSERT, 32'h0000_0030, 1'b0, 1'b0},
    '{CMD_INSERT, 32'h0000_0040, 1'b0, 1'b0},
    '{CMD_INSERT, 32'h0000_0050, 1'b0, 1'b0},
    '{CMD_INSERT, 32'h0000_0060, 1'b1, 1'b0},
    '{CMD_FIND, 32'h0000_0070, 1'b1, 1'b0},
    '{CMD_DELETE, 32'h0000_0070, 1'b1, 1'b0},
    '{CMD_FIND, 32'h0000_0050, 1'b0, 1'b0}
  };

  quadratic_probe_hash_set dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_command     (in_command),
    .in_search_key  (in_search_key),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_success    (out_success)
  );

  always #4 clk = ~clk;

  function automatic bit apply_request(cmd_t command, key_t key);
    int unsigned home;
    int unsigned slot;
    int unsigned i;
    bit done;
    bit ok;
    home = key % TABLE_SLOTS;
    done = 1'b0;
    ok = 1'b0;
    if (command == CMD_INSERT || command == CMD_FIND || command == CMD_DELETE) begin
      for (i = 0; i < TABLE_SLOTS && !done; i++) begin
        slot = (home + i * i) % TABLE_SLOTS;
        if (command == CMD_INSERT) begin
          if (!stored_full[slot] || stored_dead[slot]) begin
            stored_key[slot] = key;
            stored_full[slot] = 1'b1;
            stored_dead[slot] = 1'b0;
            ok = 1'b1;
            done = 1'b1;
          end
        end else if (!stored_full[slot]) begin
          done = 1'b1;
        end else if (!stored_dead[slot] && stored_key[slot] == key) begin
          if (command == CMD_DELETE) begin
            stored_dead[slot] = 1'b1;
          end
          ok = 1'b1;
          done = 1'b1;
        end
      end
    end
    return ok;
  endfunction

  task automatic send_request(input cmd_t command, input key_t key, input bit fixed,
                              input bit answer);
    bit predicted;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_command <= command;
    in_search_key <= key;
    @(posedge clk);
    while (in_stall) begin
      @(posedge clk);
    end
    predicted = apply_request(command, key);
    expected_success.push_back(fixed ? answer : predicted);
  endtask

  always @(posedge clk) begin
    out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
  end

  always @(posedge clk) begin : check_results
    bit want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_success.size() == 0) begin
        fail_count++;
        if (fail_count <= MAX_REPORTS) begin
          $display("unexpected result transfer: success=%b", out_success);
        end
      end else begin
        want = expected_success.pop_front();
        if (out_success !== want) begin
          fail_count++;
          if (fail_count <= MAX_REPORTS) begin
            $display("success mismatch: expected %b, got %b", want, out_success);
          end
        end
      end
    end
  end

  initial begin : stimulus
    int unsigned phase;
    int unsigned n;
    int unsigned pick;
    int unsigned k;
    key_t raw;
    cmd_t command;
    key_t key;
    for (k = 0; k < TABLE_SLOTS; k++) begin
      stored_key[k] = '0;
      stored_full[k] = 1'b0;
      stored_dead[k] = 1'b0;
    end
    send_idle_pct = 33;
    recv_stall_pct = 82;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    foreach (directed_reqs[r]) begin
      send_request(directed_reqs[r].command, directed_reqs[r].key, directed_reqs[r].fixed,
                   directed_reqs[r].answer);
    end
    for (phase = 0; phase < 3; phase++) begin
      if (phase == 1) begin
        send_idle_pct = 82;
        recv_stall_pct = 33;
      end else if (phase == 2) begin
        send_idle_pct = 0;
        recv_stall_pct = 0;
      end
      for (k = 0; k < POOL_SIZE; k++) begin
        raw = $urandom;
        key_pool[k] = (raw / TABLE_SLOTS) * TABLE_SLOTS + (k % 5);
      end
      for (n = 0; n < RANDOM_PER_PHASE; n++) begin
        pick = $urandom_range(0, 99);
        if (pick < 4) begin
          command = CMD_UNUSED;
        end else if (pick < 40) begin
          command = CMD_INSERT;
        end else if (pick < 70) begin
          command = CMD_FIND;
        end else begin
          command = CMD_DELETE;
        end
        if ($urandom_range(0, 99) < 70) begin
          key = key_pool[$urandom_range(0, POOL_SIZE - 1)];
        end else begin
          key = $urandom;
        end
        send_request(command, key, 1'b0, 1'b0);
      end
    end
    in_valid <= 1'b0;
    while (expected_success.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin : watchdog
    #5_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

/* files.f */
sv/qphs_pkg.sv
sv/qphs_front.sv
sv/qphs_queue.sv
sv/qphs_back.sv
sv/quadratic_probe_hash_set.sv
dv/tb_quadratic_probe_hash_set.sv
